>>> sv/bcmp_pkg.sv
// Shared constants, types and codes for the binomial coefficient modulo prime block.
package bcmp_pkg;

  // Field widths
  localparam int IN_W  = 10;
  localparam int RES_W = 30;

  // Modulus, Barrett reciprocal floor(2^60 / P) and Fermat exponent P-2
  localparam logic [RES_W-1:0] PRIME      = 30'd1000000007;
  localparam logic [RES_W:0]   BARRETT_MU = 31'd1152921496;
  localparam logic [RES_W-1:0] FERMAT_EXP = 30'd1000000005;

  localparam int EXP_W = RES_W;
  localparam int CNT_W = $clog2(EXP_W);

  localparam logic [RES_W-1:0] RES_ONE = 30'd1;

  // Pipeline depth of the modular multiplier
  localparam int MM_LAT = 4;

  // Operation slot tags within one round
  localparam logic TAG_SLOT0 = 1'b0;
  localparam logic TAG_SLOT1 = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_POW,
    ST_FINAL,
    ST_WAIT
  } state_t;

  typedef enum logic [1:0] {
    PH_SLOT0,
    PH_SLOT1,
    PH_WAIT
  } phase_t;

  // Multiplier request from the sequencer
  typedef struct packed {
    logic             vld;
    logic             tag;
    logic [RES_W-1:0] opa;
    logic [RES_W-1:0] opb;
  } mm_req_t;

  // Multiplier response back to the sequencer
  typedef struct packed {
    logic             vld;
    logic             tag;
    logic [RES_W-1:0] value;
  } mm_rsp_t;

endpackage

>>> sv/bcmp_mulmod.sv
// Pipelined Barrett modular multiplier, one request per cycle.
module bcmp_mulmod (
  input  logic              clk,
  input  logic              rst_n,
  input  bcmp_pkg::mm_req_t req,
  output bcmp_pkg::mm_rsp_t rsp
);

  localparam int RW = bcmp_pkg::RES_W;
  localparam logic [31:0] PrimeW = {2'b00, bcmp_pkg::PRIME};

  // Stage registers
  logic                s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic                s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r;
  logic [2*RW-1:0]     prod_r;
  logic [2*RW+1:0]     q2_r;
  logic [31:0]         p2_lo_r, p3_lo_r;
  logic [31:0]         qp_lo_r;
  logic [RW-1:0]       res_r;

  logic [2*RW-1:0]     prod_nxt;
  logic [2*RW+1:0]     q2_nxt;
  logic [2*RW:0]       qp_full;
  logic [31:0]         diff, diff1, diff2;

  // Full product, then quotient estimate, then quotient times modulus
  assign prod_nxt = (2*RW)'(req.opa) * (2*RW)'(req.opb);
  assign q2_nxt   = (2*RW+2)'(prod_r[2*RW-1:RW-1]) * (2*RW+2)'(bcmp_pkg::BARRETT_MU);
  assign qp_full  = (2*RW+1)'(q2_r[2*RW+1:RW+1]) * (2*RW+1)'(bcmp_pkg::PRIME);

  // Remainder is below three times the modulus: fold twice
  always_comb begin
    diff  = p3_lo_r - qp_lo_r;
    diff1 = (diff >= PrimeW) ? (diff - PrimeW) : diff;
    diff2 = (diff1 >= PrimeW) ? (diff1 - PrimeW) : diff1;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= req.vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    s1_tag_r <= req.tag;
    s2_tag_r <= s1_tag_r;
    s3_tag_r <= s2_tag_r;
    s4_tag_r <= s3_tag_r;
    prod_r   <= prod_nxt;
    q2_r     <= q2_nxt;
    p2_lo_r  <= prod_r[31:0];
    p3_lo_r  <= p2_lo_r;
    qp_lo_r  <= qp_full[31:0];
    res_r    <= diff2[RW-1:0];
  end

  assign rsp.vld   = s4_vld_r;
  assign rsp.tag   = s4_tag_r;
  assign rsp.value = res_r;

  a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.vld |-> (rsp.value < bcmp_pkg::PRIME))
    else $error("modular product not fully reduced");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    req.vld |-> ##4 rsp.vld)
    else $error("request did not return after pipeline latency");

  a_tag_kept: assert property (@(posedge clk) disable iff (!rst_n)
    req.vld |-> ##4 (rsp.tag == $past(req.tag, 4)))
    else $error("response tag does not match request");

endmodule

>>> sv/binomial_coefficient_mod_prime_core.sv
// Top level: sequencer for C(n, r) mod 1000000007 on one shared modular multiplier.
//
//   channel | beat fields (tdata, lowest bit first)          | dir
//   in_     | n_value[9:0], r_value[19:10], zero [23:20]     | in
//   out_    | coefficient[29:0], zero [31:30]                | out
//
// Each round issues two products into the 4-stage multiplier and waits for both.
// out_tvalid rises after r product rounds, 30 square-and-multiply rounds for the Fermat
// inverse, one final round and the load into the output register; r > n skips the rounds
// and loads 0. in_tready returns the cycle after the load.
// in_tready is high only while idle; a finished result waits in the output register
// and the next item is accepted meanwhile. Reset is synchronous, active low.
module binomial_coefficient_mod_prime_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // n_value[9:0], r_value[19:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // coefficient[29:0]
);

  localparam int IW = bcmp_pkg::IN_W;
  localparam int RW = bcmp_pkg::RES_W;
  localparam int CW = bcmp_pkg::CNT_W;

  bcmp_pkg::state_t  state_r, state_nxt;
  bcmp_pkg::phase_t  phase_r;
  bcmp_pkg::mm_req_t req;
  bcmp_pkg::mm_rsp_t rsp;

  logic [IW-1:0] n_r, r_r, i_r;
  logic [CW-1:0] bit_cnt_r;
  logic [RW-1:0] f_r, a_r, b_r, res_r;
  logic [RW-1:0] out_data_r;
  logic          out_valid_r;

  logic [IW-1:0] in_n, in_r;
  logic [IW-1:0] i_inc;
  logic          in_fire, round_done, out_load, exp_bit;

  assign in_n       = in_tdata[IW-1:0];
  assign in_r       = in_tdata[2*IW-1:IW];
  assign in_tready  = (state_r == bcmp_pkg::ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign i_inc      = i_r + IW'(1);
  assign exp_bit    = bcmp_pkg::FERMAT_EXP[bit_cnt_r];
  assign round_done = rsp.vld && (rsp.tag == bcmp_pkg::TAG_SLOT1);
  assign out_load   = (state_r == bcmp_pkg::ST_WAIT) && (!out_valid_r || out_tready);

  bcmp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcmp_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_r > in_n)            state_nxt = bcmp_pkg::ST_WAIT;
          else if (in_r == IW'(0))    state_nxt = bcmp_pkg::ST_POW;
          else                        state_nxt = bcmp_pkg::ST_PROD;
        end
      end
      bcmp_pkg::ST_PROD: begin
        if (round_done && (i_inc == r_r)) state_nxt = bcmp_pkg::ST_POW;
      end
      bcmp_pkg::ST_POW: begin
        if (round_done && (bit_cnt_r == CW'(bcmp_pkg::EXP_W - 1)))
          state_nxt = bcmp_pkg::ST_FINAL;
      end
      bcmp_pkg::ST_FINAL: begin
        if (round_done) state_nxt = bcmp_pkg::ST_WAIT;
      end
      bcmp_pkg::ST_WAIT: begin
        if (out_load) state_nxt = bcmp_pkg::ST_IDLE;
      end
      default: state_nxt = bcmp_pkg::ST_IDLE;
    endcase
  end

  // Issue operands to the multiplier
  always_comb begin
    req.vld = 1'b0;
    req.tag = (phase_r == bcmp_pkg::PH_SLOT1) ? bcmp_pkg::TAG_SLOT1 : bcmp_pkg::TAG_SLOT0;
    req.opa = b_r;
    req.opb = b_r;
    unique case (state_r)
      bcmp_pkg::ST_PROD: begin
        req.vld = (phase_r != bcmp_pkg::PH_WAIT);
        if (phase_r == bcmp_pkg::PH_SLOT0) begin
          req.opa = f_r;
          req.opb = RW'(n_r - i_r);
        end else begin
          req.opa = b_r;
          req.opb = RW'(i_inc);
        end
      end
      bcmp_pkg::ST_POW: begin
        req.vld = (phase_r != bcmp_pkg::PH_WAIT);
        if (phase_r == bcmp_pkg::PH_SLOT0) begin
          req.opa = a_r;
          req.opb = exp_bit ? b_r : bcmp_pkg::RES_ONE;
        end
      end
      bcmp_pkg::ST_FINAL: begin
        req.vld = (phase_r != bcmp_pkg::PH_WAIT);
        if (phase_r == bcmp_pkg::PH_SLOT0) begin
          req.opa = f_r;
          req.opb = a_r;
        end
      end
      bcmp_pkg::ST_IDLE, bcmp_pkg::ST_WAIT: begin
        req.vld = 1'b0;
      end
      default: req.vld = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bcmp_pkg::ST_IDLE;
      phase_r     <= bcmp_pkg::PH_SLOT0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (round_done) begin
        phase_r <= bcmp_pkg::PH_SLOT0;
      end else if (req.vld && (phase_r == bcmp_pkg::PH_SLOT0)) begin
        phase_r <= bcmp_pkg::PH_SLOT1;
      end else if (req.vld) begin
        phase_r <= bcmp_pkg::PH_WAIT;
      end
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Operands, running products and result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      n_r       <= in_n;
      r_r       <= in_r;
      i_r       <= '0;
      bit_cnt_r <= '0;
      f_r       <= bcmp_pkg::RES_ONE;
      a_r       <= bcmp_pkg::RES_ONE;
      b_r       <= bcmp_pkg::RES_ONE;
      res_r     <= '0;
    end else if (rsp.vld) begin
      unique case (state_r)
        bcmp_pkg::ST_PROD: begin
          if (rsp.tag == bcmp_pkg::TAG_SLOT0) begin
            f_r <= rsp.value;
          end else begin
            b_r <= rsp.value;
            i_r <= i_inc;
          end
        end
        bcmp_pkg::ST_POW: begin
          if (rsp.tag == bcmp_pkg::TAG_SLOT0) begin
            a_r <= rsp.value;
          end else begin
            b_r       <= rsp.value;
            bit_cnt_r <= bit_cnt_r + CW'(1);
          end
        end
        bcmp_pkg::ST_FINAL: begin
          if (rsp.tag == bcmp_pkg::TAG_SLOT0) res_r <= rsp.value;
        end
        default: ;
      endcase
    end
    if (out_load) out_data_r <= res_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r};

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bcmp_pkg::ST_IDLE) |-> !rsp.vld)
    else $error("multiplier result returned while idle");

  a_issue_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    req.vld |-> (state_r == bcmp_pkg::ST_PROD || state_r == bcmp_pkg::ST_POW ||
                 state_r == bcmp_pkg::ST_FINAL))
    else $error("multiplier issue outside a working state");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bcmp_pkg::ST_PROD) |-> (i_r < r_r))
    else $error("product round count ran past r");

endmodule
